>>> hdl/ibm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibm_pkg
// Shared types, sizes and codes of the bit-banged I2C master.
// ---------------------------------------------------------------------------
package ibm_pkg;

  // depth of the write byte buffer
  localparam int WRITE_DEPTH = 16;
  localparam int BUF_AW      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  // counts that must hold WRITE_DEPTH itself
  localparam int CNT_W       = $clog2(WRITE_DEPTH + 1);
  // width for comparing a 5-bit count against the depth
  localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;

  // request operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // transaction status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_START_FAIL = 3'd1;
  localparam logic [2:0] ST_ADDR_NACK  = 3'd2;
  localparam logic [2:0] ST_DATA_NACK  = 3'd3;
  localparam logic [2:0] ST_RADDR_NACK = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] device_address;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic [7:0] write_data;
    logic       sda_sampled;
    logic       scl_sampled;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  // write port of the byte buffer
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

>>> hdl/ibm_wbuf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibm_wbuf
// Generic RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ibm_wbuf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // contents undefined until loaded, so no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/ibm_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibm_seq
// Bus sequencer: one phase step per accepted request, result formed alongside.
// ---------------------------------------------------------------------------
module ibm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  ibm_pkg::in_t               req,
  input  logic [7:0]                 buf_rd_data,
  output logic [ibm_pkg::BUF_AW-1:0] buf_rd_addr,
  output ibm_pkg::buf_wr_t           buf_wr,
  output ibm_pkg::out_t              res
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_CHK = 5'd1;
  localparam logic [4:0] PH_START_LOW = 5'd2;
  localparam logic [4:0] PH_WBIT_LOW  = 5'd3;
  localparam logic [4:0] PH_WBIT_HIGH = 5'd4;
  localparam logic [4:0] PH_WACK_LOW  = 5'd5;
  localparam logic [4:0] PH_WACK_HIGH = 5'd6;
  localparam logic [4:0] PH_RST1      = 5'd7;
  localparam logic [4:0] PH_RST2      = 5'd8;
  localparam logic [4:0] PH_RBIT_LOW  = 5'd9;
  localparam logic [4:0] PH_RBIT_HIGH = 5'd10;
  localparam logic [4:0] PH_RACK1     = 5'd11;
  localparam logic [4:0] PH_RACK2     = 5'd12;
  localparam logic [4:0] PH_RACK3     = 5'd13;
  localparam logic [4:0] PH_RACK4     = 5'd14;
  localparam logic [4:0] PH_STOP1     = 5'd15;
  localparam logic [4:0] PH_STOP2     = 5'd16;
  localparam logic [4:0] PH_STOP3     = 5'd17;

  localparam logic [1:0] KIND_ADDR_W = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ADDR_R = 2'd2;

  localparam logic [ibm_pkg::CNT_W-1:0] DEPTH_CNT = ibm_pkg::CNT_W'(ibm_pkg::WRITE_DEPTH);
  localparam logic [ibm_pkg::CMP_W-1:0] DEPTH_CMP = ibm_pkg::CMP_W'(ibm_pkg::WRITE_DEPTH);

  logic [4:0]                phase_r,    phase_nxt;
  logic [3:0]                bit_cnt_r,  bit_cnt_nxt;
  logic [7:0]                shift_r,    shift_nxt;
  logic [ibm_pkg::CNT_W-1:0] sent_r,     sent_nxt;
  logic [ibm_pkg::CNT_W-1:0] total_r,    total_nxt;
  logic [ibm_pkg::CNT_W-1:0] load_idx_r, load_idx_nxt;
  logic [4:0]                reads_r,    reads_nxt;
  logic [6:0]                addr_r,     addr_nxt;
  logic [2:0]                status_r,   status_nxt;
  logic                      rmode_r,    rmode_nxt;
  logic [1:0]                kind_r,     kind_nxt;
  logic                      scl_r,      scl_nxt;
  logic                      sda_r,      sda_nxt;

  logic       done;
  logic       rd_valid;
  logic [7:0] rd_byte;
  logic       do_byte;
  logic [1:0] byte_kind;
  logic [7:0] byte_val;
  logic       do_stop;
  logic [2:0] stop_st;
  logic       do_read;
  logic [3:0] cnt_inc;
  logic [7:0] rshift;
  logic [ibm_pkg::CMP_W-1:0] wc_ext;

  assign buf_rd_addr = sent_r[ibm_pkg::BUF_AW-1:0];
  assign cnt_inc     = bit_cnt_r + 4'd1;
  assign rshift      = {shift_r[6:0], req.sda_sampled};
  assign wc_ext      = ibm_pkg::CMP_W'(req.write_count);

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    sent_nxt     = sent_r;
    total_nxt    = total_r;
    load_idx_nxt = load_idx_r;
    reads_nxt    = reads_r;
    addr_nxt     = addr_r;
    status_nxt   = status_r;
    rmode_nxt    = rmode_r;
    kind_nxt     = kind_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    done         = 1'b0;
    rd_valid     = 1'b0;
    rd_byte      = 8'd0;
    do_byte      = 1'b0;
    byte_kind    = KIND_DATA;
    byte_val     = 8'd0;
    do_stop      = 1'b0;
    stop_st      = ibm_pkg::ST_OK;
    do_read      = 1'b0;
    buf_wr.en    = 1'b0;
    buf_wr.addr  = load_idx_r[ibm_pkg::BUF_AW-1:0];
    buf_wr.data  = req.write_data;

    if (req.operation == ibm_pkg::OP_TICK) begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_START_CHK: begin
          if (!req.sda_sampled || !req.scl_sampled) begin
            if (rmode_r) begin
              do_stop = 1'b1;
              stop_st = ibm_pkg::ST_START_FAIL;
            end else begin
              status_nxt = ibm_pkg::ST_START_FAIL;
              done       = 1'b1;
              scl_nxt    = 1'b1;
              sda_nxt    = 1'b1;
              phase_nxt  = PH_IDLE;
            end
          end else begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_START_LOW;
          end
        end
        PH_START_LOW: begin
          do_byte   = 1'b1;
          byte_kind = KIND_ADDR_W;
          byte_val  = {addr_r, 1'b0};
        end
        PH_WBIT_LOW: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WBIT_HIGH;
        end
        PH_WBIT_HIGH: begin
          bit_cnt_nxt = cnt_inc;
          if (cnt_inc < 4'd8) begin
            scl_nxt   = 1'b0;
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_WBIT_LOW;
          end else begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            phase_nxt = PH_WACK_LOW;
          end
        end
        PH_WACK_LOW: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_WACK_HIGH;
        end
        PH_WACK_HIGH: begin
          if (req.sda_sampled) begin
            do_stop = 1'b1;
            if (kind_r == KIND_ADDR_W) begin
              stop_st = ibm_pkg::ST_ADDR_NACK;
            end else if (kind_r == KIND_DATA) begin
              stop_st = ibm_pkg::ST_DATA_NACK;
            end else begin
              stop_st = ibm_pkg::ST_RADDR_NACK;
            end
          end else if (kind_r == KIND_ADDR_R) begin
            if (reads_r != 5'd0) begin
              do_read = 1'b1;
            end else begin
              do_stop = 1'b1;
            end
          end else if (sent_r < total_r) begin
            sent_nxt  = sent_r + ibm_pkg::CNT_W'(1);
            do_byte   = 1'b1;
            byte_kind = KIND_DATA;
            byte_val  = buf_rd_data;
          end else if (!rmode_r) begin
            do_stop = 1'b1;
          end else begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_RST1;
          end
        end
        PH_RST1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          phase_nxt = PH_RST2;
        end
        PH_RST2: begin
          do_byte   = 1'b1;
          byte_kind = KIND_ADDR_R;
          byte_val  = {addr_r, 1'b1};
        end
        PH_RBIT_LOW: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_RBIT_HIGH;
        end
        PH_RBIT_HIGH: begin
          shift_nxt   = rshift;
          bit_cnt_nxt = cnt_inc;
          scl_nxt     = 1'b0;
          sda_nxt     = 1'b1;
          if (cnt_inc < 4'd8) begin
            phase_nxt = PH_RBIT_LOW;
          end else begin
            rd_valid = 1'b1;
            rd_byte  = rshift;
            if (reads_r != 5'd0) begin
              reads_nxt = reads_r - 5'd1;
            end
            phase_nxt = PH_RACK1;
          end
        end
        PH_RACK1: begin
          scl_nxt   = 1'b0;
          sda_nxt   = (reads_r == 5'd0);
          phase_nxt = PH_RACK2;
        end
        PH_RACK2: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RACK3;
        end
        PH_RACK3: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RACK4;
        end
        PH_RACK4: begin
          if (reads_r != 5'd0) begin
            do_read = 1'b1;
          end else begin
            do_stop = 1'b1;
          end
        end
        PH_STOP1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          phase_nxt = PH_STOP2;
        end
        PH_STOP2: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_STOP3;
        end
        PH_STOP3: begin
          done      = 1'b1;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
        end
      endcase

      // first bit of a new byte goes out with the low clock
      if (do_byte) begin
        kind_nxt    = byte_kind;
        bit_cnt_nxt = 4'd0;
        scl_nxt     = 1'b0;
        sda_nxt     = byte_val[7];
        shift_nxt   = {byte_val[6:0], 1'b0};
        phase_nxt   = PH_WBIT_LOW;
      end
      if (do_stop) begin
        status_nxt = stop_st;
        scl_nxt    = 1'b0;
        sda_nxt    = 1'b0;
        phase_nxt  = PH_STOP1;
      end
      if (do_read) begin
        shift_nxt   = 8'd0;
        bit_cnt_nxt = 4'd0;
        scl_nxt     = 1'b0;
        sda_nxt     = 1'b1;
        phase_nxt   = PH_RBIT_LOW;
      end
    end else if (req.operation == ibm_pkg::OP_BEGIN && phase_r == PH_IDLE) begin
      addr_nxt     = req.device_address;
      total_nxt    = (wc_ext > DEPTH_CMP) ? DEPTH_CNT : ibm_pkg::CNT_W'(wc_ext);
      reads_nxt    = req.read_count;
      rmode_nxt    = (req.read_count != 5'd0);
      sent_nxt     = '0;
      bit_cnt_nxt  = 4'd0;
      shift_nxt    = 8'd0;
      load_idx_nxt = '0;
      scl_nxt      = 1'b1;
      sda_nxt      = 1'b1;
      phase_nxt    = PH_START_CHK;
    end else if (req.operation == ibm_pkg::OP_LOAD && phase_r == PH_IDLE) begin
      if (load_idx_r != DEPTH_CNT) begin
        buf_wr.en    = accept;
        load_idx_nxt = load_idx_r + ibm_pkg::CNT_W'(1);
      end
    end

    res.scl_release = scl_nxt;
    res.sda_release = sda_nxt;
    res.read_data   = rd_byte;
    res.read_valid  = rd_valid;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.status      = done ? status_nxt : ibm_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      sent_r     <= '0;
      total_r    <= '0;
      load_idx_r <= '0;
      reads_r    <= 5'd0;
      addr_r     <= 7'd0;
      status_r   <= ibm_pkg::ST_OK;
      rmode_r    <= 1'b0;
      kind_r     <= KIND_ADDR_W;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      sent_r     <= sent_nxt;
      total_r    <= total_nxt;
      load_idx_r <= load_idx_nxt;
      reads_r    <= reads_nxt;
      addr_r     <= addr_nxt;
      status_r   <= status_nxt;
      rmode_r    <= rmode_nxt;
      kind_r     <= kind_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

  // finishing request leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.done_res |=> phase_r == PH_IDLE)
    else $error("done reported but sequencer not idle");

  // a received byte is always followed by the ack phases
  a_read_ack: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res.read_valid |=> phase_r == PH_RACK1)
    else $error("read byte not followed by ack phase");

  // bytes sent never pass the latched total
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r <= total_r)
    else $error("sent count beyond write total");

  // bit counter stays within one byte
  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter out of range");

endmodule

>>> hdl/ibm_outq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ibm_outq
// Two-entry result queue: output register plus skid slot.
// ---------------------------------------------------------------------------
module ibm_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ibm_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output ibm_pkg::out_t out_data
);

  logic [1:0]    cnt_r, cnt_nxt;
  ibm_pkg::out_t q0_r;
  ibm_pkg::out_t q1_r;
  logic          pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: begin
        if (push) begin
          q0_r <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          q0_r <= push_data;
        end else if (push) begin
          q1_r <= push_data;
        end
      end
      default: begin
        if (pop) begin
          q0_r <= q1_r;
        end
      end
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full result queue");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("result queue count did not grow on push");

endmodule

>>> hdl/i2c_bitbang_master_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_bitbang_master_top
// Results: each accepted request's result is registered into the result queue.
// Throughput: one request per cycle; the sequencer takes one phase step per
//   request, and in_stall rises only while two results wait in the queue.
// Reset (rst_n low, synchronous): sequencer idle, both lines released,
//   counters and status cleared, result queue emptied; buffer bytes kept.
// ---------------------------------------------------------------------------
// Open-drain I2C master stepped by requests. A tick request stands for one
// bus delay interval and carries the line levels sampled at its end; begin
// and load requests are taken only while idle. Each request yields exactly
// one result with the line drive for the coming interval.
// ---------------------------------------------------------------------------
module i2c_bitbang_master_top (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_valid,
  output logic          in_stall,
  input  ibm_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output ibm_pkg::out_t out_data
);

  logic                       accept;
  ibm_pkg::out_t              res;
  ibm_pkg::buf_wr_t           buf_wr;
  logic [ibm_pkg::BUF_AW-1:0] buf_rd_addr;
  logic [7:0]                 buf_rd_data;
  logic                       q_full;

  // stall is registered-state only: the queue is full
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // phase sequencer; state moves only on an accepted request
  ibm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req         (in_data),
    .buf_rd_data (buf_rd_data),
    .buf_rd_addr (buf_rd_addr),
    .buf_wr      (buf_wr),
    .res         (res)
  );

  // write bytes, loaded while idle, read out by bytes-sent index; the read
  // is registered, but the index holds still for a whole byte, so the next
  // byte is ready long before the ack phase asks for it
  ibm_wbuf #(
    .WIDTH (8),
    .DEPTH (ibm_pkg::WRITE_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (buf_wr.en),
    .wr_addr (buf_wr.addr),
    .wr_data (buf_wr.data),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  // result register with skid slot, so a waiting result does not block intake
  ibm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-banged I2C master.
// ---------------------------------------------------------------------------
// A short table of directed requests comes first. It covers the idle corners,
// both kinds of start failure and the requests that are ignored while busy.
// A random phase follows. It mostly builds whole transactions: buffer loads,
// a begin, then ticks carrying line levels from a loosely behaved slave. A
// little noise is mixed in. Every accepted request is run through a local
// model of the sequencer, and each result is checked field by field, in
// order. Both sides idle in random bursts, and once the receiver holds off
// long enough for the request side to back up.
// ---------------------------------------------------------------------------
module testbench;

  // operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int REQ_TARGET      = 1750;             // requests sent
  localparam int QUIET_FROM      = REQ_TARGET - 250; // no idling beyond this point
  localparam int PRESSURE_AT     = 400;
  localparam int PRESSURE_CYCLES = 200;
  localparam int DRAIN_LIMIT     = 10000;
  localparam int TAIL_CYCLES     = 8;

  typedef enum logic [4:0] {
    BUS_IDLE, BUS_START_CHK, BUS_START_LOW, BUS_WBIT_LOW, BUS_WBIT_HIGH,
    BUS_WACK_LOW, BUS_WACK_HIGH, BUS_RST1, BUS_RST2, BUS_RBIT_LOW,
    BUS_RBIT_HIGH, BUS_RACK1, BUS_RACK2, BUS_RACK3, BUS_RACK4,
    BUS_STOP1, BUS_STOP2, BUS_STOP3
  } bus_phase_e;

  typedef enum logic [1:0] {BYTE_ADDR_W, BYTE_DATA, BYTE_ADDR_R} byte_kind_e;

  typedef struct packed {
    ibm_pkg::in_t  rq;
    logic          typed;   // res holds a hand-written expectation
    ibm_pkg::out_t res;
  } dir_row_t;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  ibm_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ibm_pkg::out_t out_data;

  i2c_bitbang_master_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Local model of the sequencer. It starts in the reset state and advances
  // once per accepted request.
  // -------------------------------------------------------------------------
  logic [7:0]                      wbuf [ibm_pkg::WRITE_DEPTH];
  logic [ibm_pkg::WRITE_DEPTH-1:0] loaded_mask = '0;   // buffer entries ever written
  int unsigned                     load_idx    = 0;
  int unsigned                     bytes_sent  = 0;
  int unsigned                     write_total = 0;
  bus_phase_e                      bus_phase   = BUS_IDLE;
  logic [3:0]                      bit_cnt     = '0;
  logic [7:0]                      shreg       = '0;
  logic [4:0]                      reads_left  = '0;
  logic [6:0]                      target_addr = '0;
  logic [2:0]                      held_status = ibm_pkg::ST_OK;
  logic                            read_mode   = 1'b0;
  byte_kind_e                      byte_kind   = BYTE_ADDR_W;
  logic                            scl_drv     = 1'b1;
  logic                            sda_drv     = 1'b1;
  logic                            done_now    = 1'b0;

  function automatic void set_lines(logic scl, logic sda, bus_phase_e nxt);
    scl_drv   = scl;
    sda_drv   = sda;
    bus_phase = nxt;
  endfunction

  function automatic void shift_out_bit();
    set_lines(1'b0, shreg[7], BUS_WBIT_LOW);
    shreg = shreg << 1;
  endfunction

  function automatic void load_byte(byte_kind_e kind, logic [7:0] value);
    byte_kind = kind;
    shreg     = value;
    bit_cnt   = '0;
    shift_out_bit();
  endfunction

  function automatic void end_transfer(logic [2:0] st);
    held_status = st;
    done_now    = 1'b1;
    set_lines(1'b1, 1'b1, BUS_IDLE);
  endfunction

  function automatic void begin_stop(logic [2:0] st);
    held_status = st;
    set_lines(1'b0, 1'b0, BUS_STOP1);
  endfunction

  function automatic void begin_read_byte();
    shreg   = '0;
    bit_cnt = '0;
    set_lines(1'b0, 1'b1, BUS_RBIT_LOW);
  endfunction

  // One request in, one result out
  task automatic master_step(input ibm_pkg::in_t rq, output ibm_pkg::out_t rs);
    logic [7:0] next_byte;
    rs       = '0;
    done_now = 1'b0;
    case (rq.operation)
      ibm_pkg::OP_TICK: begin
        case (bus_phase)
          BUS_IDLE: ;
          BUS_START_CHK: begin
            // either line held low by someone else: no start
            if (!rq.sda_sampled || !rq.scl_sampled) begin
              if (read_mode) begin_stop(ibm_pkg::ST_START_FAIL);
              else end_transfer(ibm_pkg::ST_START_FAIL);
            end else begin
              set_lines(1'b1, 1'b0, BUS_START_LOW);
            end
          end
          BUS_START_LOW: load_byte(BYTE_ADDR_W, {target_addr, 1'b0});
          BUS_WBIT_LOW:  set_lines(1'b1, sda_drv, BUS_WBIT_HIGH);
          BUS_WBIT_HIGH: begin
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt < 4'd8) shift_out_bit();
            else set_lines(1'b0, 1'b1, BUS_WACK_LOW);
          end
          BUS_WACK_LOW:  set_lines(1'b1, 1'b1, BUS_WACK_HIGH);
          BUS_WACK_HIGH: begin
            if (rq.sda_sampled) begin
              case (byte_kind)
                BYTE_ADDR_W: begin_stop(ibm_pkg::ST_ADDR_NACK);
                BYTE_DATA:   begin_stop(ibm_pkg::ST_DATA_NACK);
                default:     begin_stop(ibm_pkg::ST_RADDR_NACK);
              endcase
            end else if (byte_kind == BYTE_ADDR_R) begin
              if (reads_left != 0) begin_read_byte();
              else begin_stop(ibm_pkg::ST_OK);
            end else if (bytes_sent < write_total) begin
              next_byte  = wbuf[bytes_sent];
              bytes_sent = bytes_sent + 1;
              load_byte(BYTE_DATA, next_byte);
            end else if (!read_mode) begin
              begin_stop(ibm_pkg::ST_OK);
            end else begin
              set_lines(1'b1, 1'b1, BUS_RST1);
            end
          end
          BUS_RST1:      set_lines(1'b1, 1'b0, BUS_RST2);
          BUS_RST2:      load_byte(BYTE_ADDR_R, {target_addr, 1'b1});
          BUS_RBIT_LOW:  set_lines(1'b1, 1'b1, BUS_RBIT_HIGH);
          BUS_RBIT_HIGH: begin
            shreg   = {shreg[6:0], rq.sda_sampled};
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt < 4'd8) begin
              set_lines(1'b0, 1'b1, BUS_RBIT_LOW);
            end else begin
              rs.read_data  = shreg;
              rs.read_valid = 1'b1;
              if (reads_left != 0) reads_left = reads_left - 1'b1;
              set_lines(1'b0, 1'b1, BUS_RACK1);
            end
          end
          // ack every byte but the last
          BUS_RACK1: set_lines(1'b0, reads_left == 0, BUS_RACK2);
          BUS_RACK2: set_lines(1'b1, sda_drv, BUS_RACK3);
          BUS_RACK3: set_lines(1'b0, sda_drv, BUS_RACK4);
          BUS_RACK4: begin
            if (reads_left != 0) begin_read_byte();
            else begin_stop(ibm_pkg::ST_OK);
          end
          BUS_STOP1: set_lines(1'b1, 1'b0, BUS_STOP2);
          BUS_STOP2: set_lines(1'b1, 1'b1, BUS_STOP3);
          BUS_STOP3: end_transfer(held_status);
          default:   set_lines(1'b1, 1'b1, BUS_IDLE);
        endcase
      end
      ibm_pkg::OP_BEGIN: begin
        if (bus_phase == BUS_IDLE) begin
          target_addr = rq.device_address;
          write_total = (rq.write_count > ibm_pkg::WRITE_DEPTH) ? ibm_pkg::WRITE_DEPTH
                                                                : rq.write_count;
          reads_left  = rq.read_count;
          read_mode   = (rq.read_count != 0);
          bytes_sent  = 0;
          bit_cnt     = '0;
          shreg       = '0;
          load_idx    = 0;
          set_lines(1'b1, 1'b1, BUS_START_CHK);
        end
      end
      ibm_pkg::OP_LOAD: begin
        // buffer full: dropped
        if (bus_phase == BUS_IDLE && load_idx < ibm_pkg::WRITE_DEPTH) begin
          wbuf[load_idx]        = rq.write_data;
          loaded_mask[load_idx] = 1'b1;
          load_idx              = load_idx + 1;
        end
      end
      default: ;
    endcase
    rs.scl_release = scl_drv;
    rs.sda_release = sda_drv;
    rs.busy_res    = (bus_phase != BUS_IDLE);
    rs.done_res    = done_now;
    rs.status      = done_now ? held_status : ibm_pkg::ST_OK;
  endtask

  // -------------------------------------------------------------------------
  // Random request source. It looks at the model state to decide what comes
  // next, so that most of the traffic consists of whole transactions.
  // -------------------------------------------------------------------------
  int plan_loads = 0;
  bit plan_begin = 1'b0;

  function automatic ibm_pkg::in_t next_request();
    logic [31:0]  rnd;
    ibm_pkg::in_t rq;
    int unsigned  prefix;
    int unsigned  pick;
    rnd = $urandom();
    rq  = rnd[$bits(ibm_pkg::in_t)-1:0];
    if (bus_phase != BUS_IDLE) begin
      if ($urandom_range(0, 11) == 0) begin
        // begin, load or unused code while busy: must be ignored
        case ($urandom_range(0, 2))
          0:       rq.operation = ibm_pkg::OP_BEGIN;
          1:       rq.operation = ibm_pkg::OP_LOAD;
          default: rq.operation = OP_UNUSED;
        endcase
      end else begin
        rq.operation = ibm_pkg::OP_TICK;
        case (bus_phase)
          BUS_START_CHK: begin
            if ($urandom_range(0, 9) != 0) begin
              {rq.sda_sampled, rq.scl_sampled} = 2'b11;
            end else begin
              {rq.sda_sampled, rq.scl_sampled} = 2'($urandom_range(0, 2));
            end
          end
          // the slave acks nine times in ten
          BUS_WACK_HIGH: rq.sda_sampled = ($urandom_range(0, 9) == 0);
          default: ;
        endcase
      end
    end else if ($urandom_range(0, 9) == 0) begin
      rq.operation = $urandom_range(0, 1) ? OP_UNUSED : ibm_pkg::OP_TICK;
    end else begin
      if (!plan_begin) begin
        plan_begin = 1'b1;
        // now and then load past the end of the buffer
        plan_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                 : $urandom_range(0, 4);
      end
      if (plan_loads > 0) begin
        plan_loads   = plan_loads - 1;
        rq.operation = ibm_pkg::OP_LOAD;
      end else begin
        plan_begin   = 1'b0;
        rq.operation = ibm_pkg::OP_BEGIN;
        // only ever send buffer entries that hold a written byte
        prefix = 0;
        while (prefix < ibm_pkg::WRITE_DEPTH && loaded_mask[prefix]) prefix++;
        if (prefix == ibm_pkg::WRITE_DEPTH && $urandom_range(0, 3) == 0) begin
          rq.write_count = 5'($urandom_range(ibm_pkg::WRITE_DEPTH + 1, 31));
        end else begin
          rq.write_count = 5'($urandom_range(0, prefix));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)      rq.read_count = '0;
        else if (pick < 90) rq.read_count = 5'($urandom_range(1, 4));
        else if (pick < 98) rq.read_count = 5'($urandom_range(5, 16));
        else                rq.read_count = 5'($urandom_range(17, 31));
      end
    end
    return rq;
  endfunction

  function automatic ibm_pkg::out_t line_res(logic scl, logic sda, logic busy,
                                             logic done, logic [2:0] st);
    ibm_pkg::out_t rs;
    rs             = '0;
    rs.scl_release = scl;
    rs.sda_release = sda;
    rs.busy_res    = busy;
    rs.done_res    = done;
    rs.status      = st;
    return rs;
  endfunction

  dir_row_t dir_rows[$];

  function automatic void add_row(ibm_pkg::in_t rq, logic typed, ibm_pkg::out_t res);
    dir_rows.push_back({rq, typed, res});
  endfunction

  // -------------------------------------------------------------------------
  // Request side: directed table first, then the random source
  // -------------------------------------------------------------------------
  ibm_pkg::out_t bus_results_due[$];
  int            items_used = 0;
  int            mismatches = 0;
  bit            stim_done  = 1'b0;
  int            dir_idx    = 0;
  int            gap_left   = 0;
  logic          req_typed  = 1'b0;
  ibm_pkg::out_t req_expect = '0;
  logic          quiet;

  assign quiet = (items_used >= QUIET_FROM);

  always @(posedge clk) begin
    ibm_pkg::out_t predicted;
    if (rst_n && !stim_done) begin
      if (in_valid && !in_stall) begin
        master_step(in_data, predicted);
        if (req_typed) predicted = req_expect;
        bus_results_due.push_back(predicted);
        items_used++;
      end
      // the payload may only change while the request is not stalled
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (dir_idx >= dir_rows.size() && items_used >= REQ_TARGET &&
                     bus_phase == BUS_IDLE) begin
          in_valid  <= 1'b0;
          stim_done = 1'b1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (dir_idx < dir_rows.size()) begin
          in_data    <= dir_rows[dir_idx].rq;
          req_typed  <= dir_rows[dir_idx].typed;
          req_expect <= dir_rows[dir_idx].res;
          in_valid   <= 1'b1;
          dir_idx++;
        end else begin
          in_data   <= next_request();
          req_typed <= 1'b0;
          in_valid  <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off that lets the
  // result queue fill so that in_stall has to rise
  // -------------------------------------------------------------------------
  int hold_left     = 0;
  bit pressure_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (!pressure_done && items_used >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
        out_stall     <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Each accepted result is matched against the oldest outstanding prediction
  always @(posedge clk) begin
    ibm_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        $error("result %h arrived with nothing outstanding", out_data);
        mismatches++;
      end else begin
        want = bus_results_due.pop_front();
        check_field("scl_release", want.scl_release, out_data.scl_release);
        check_field("sda_release", want.sda_release, out_data.sda_release);
        check_field("read_data",   want.read_data,   out_data.read_data);
        check_field("read_valid",  want.read_valid,  out_data.read_valid);
        check_field("busy_res",    want.busy_res,    out_data.busy_res);
        check_field("done_res",    want.done_res,    out_data.done_res);
        check_field("status",      want.status,      out_data.status);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Directed table, reset and end of run
  // -------------------------------------------------------------------------
  initial begin
    int waited;
    // idle corners: unused code, idle tick with both lines low, loads at the extremes
    add_row('{OP_UNUSED, 7'h00, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b0, 1'b0}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_LOAD, 7'h00, 5'd0, 5'd0, 8'hFF, 1'b0, 1'b0}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_LOAD, 7'h7F, 5'h1F, 5'h1F, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b0, ibm_pkg::ST_OK));
    // write-only begin, loads and begins ignored while busy, then SDA low at start
    add_row('{ibm_pkg::OP_BEGIN, 7'h7F, 5'd2, 5'd0, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b1, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_LOAD, 7'h00, 5'd0, 5'd0, 8'hAA, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b1, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_BEGIN, 7'h00, 5'h1F, 5'h1F, 8'h00, 1'b0, 1'b0}, 1'b1,
            line_res(1'b1, 1'b1, 1'b1, 1'b0, ibm_pkg::ST_OK));
    // no stop after a failed write-only start
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b1, ibm_pkg::ST_START_FAIL));
    // write-read with the largest read count; SCL low at start, so a stop follows
    add_row('{ibm_pkg::OP_BEGIN, 7'h00, 5'd0, 5'h1F, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b1, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b1, 1'b0}, 1'b1,
            line_res(1'b0, 1'b0, 1'b1, 1'b0, ibm_pkg::ST_OK));
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1}, 1'b0, '0);
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1}, 1'b0, '0);
    add_row('{ibm_pkg::OP_TICK, 7'h00, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b0, 1'b1, ibm_pkg::ST_START_FAIL));
    // a real write-read of the two loaded bytes; the random ticks carry it on
    add_row('{ibm_pkg::OP_BEGIN, 7'h55, 5'd2, 5'd1, 8'h00, 1'b1, 1'b1}, 1'b1,
            line_res(1'b1, 1'b1, 1'b1, 1'b0, ibm_pkg::ST_OK));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done) @(posedge clk);
    waited = 0;
    while (bus_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // then keep watching for stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bus_results_due.size() != 0) begin
      $error("%0d results never arrived", bus_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
